// ===== design/kopc_pkg.sv =====
// Package for the k-mer order path cost unit.
// Holds field widths, register indexes, state encodings and control structs.
// No dependencies.
package kopc_pkg;

	localparam int RANK_W      = 11;
	localparam int STEP_W      = 5;
	localparam int KSEL_W      = 4;
	localparam int KCLAMP_W    = 5;
	localparam int COST_W      = 18;
	localparam int KMER_FLD_W  = 10;

	localparam int S_TDATA_W   = 56;
	localparam int M_TDATA_W   = 24;

	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_PATH_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KMER_BITS   = 1'd1;

	localparam logic [STEP_W-1:0] PATH_LENGTH_RST = 5'd8;
	localparam logic [KSEL_W-1:0] KMER_BITS_RST   = 4'd10;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		T_IDLE,
		T_START,
		T_RUN
	} top_state_t;

	typedef enum logic [2:0] {
		W_IDLE,
		W_VISIT,
		W_EVAL,
		W_POP,
		W_DONE
	} walk_state_t;

	typedef struct packed {
		logic start;
		logic ack;
	} walk_ctl_t;

	typedef struct packed {
		logic              done;
		logic [COST_W-1:0] cost;
	} walk_stat_t;

endpackage

// ===== design/kopc_rank_mem.sv =====
// Rank table memory: one write port, one read port with registered data.
// Depends on nothing; contents are undefined until written.
module kopc_rank_mem #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 11
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [(1 << ADDR_W)];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/kopc_walker.sv =====
// Depth-first walker: forward walk, then backward walk, with an explicit stack.
// Uses kopc_pkg; reads ranks through the rank memory's registered read port.
module kopc_walker
	import kopc_pkg::*;
#(
	parameter int NODE_W         = 10,
	parameter int PATH_STEPS_MAX = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  walk_ctl_t         ctl,
	input  logic [NODE_W-1:0] start_node,
	input  logic [NODE_W-1:0] target_node,
	input  logic [NODE_W-1:0] node_mask,
	input  logic [NODE_W-1:0] node_high,
	input  logic [RANK_W-1:0] rank_limit,
	input  logic [STEP_W-1:0] steps,
	output logic              rd_en,
	output logic [NODE_W-1:0] rd_addr,
	input  logic [RANK_W-1:0] rd_data,
	output walk_stat_t        stat
);

	localparam int LVL_W  = $clog2(PATH_STEPS_MAX + 1);
	localparam int STK_AW = (PATH_STEPS_MAX > 1) ? $clog2(PATH_STEPS_MAX) : 1;

	walk_state_t       state_q, state_d;
	logic [LVL_W-1:0]  sp_q, sp_d;
	logic [NODE_W-1:0] cur_q, cur_d;
	logic              seen_q, seen_d;
	logic              bwd_q, bwd_d;
	logic [COST_W-1:0] cnt_q, cnt_d;

	logic [NODE_W-1:0] node_stk_q [PATH_STEPS_MAX];
	logic              seen_stk_q [PATH_STEPS_MAX];
	logic              dir_stk_q  [PATH_STEPS_MAX];

	logic              push;
	logic              set_dir;
	logic [STK_AW-1:0] push_idx;
	logic [STK_AW-1:0] top_idx;
	logic [NODE_W-1:0] node_top;
	logic              seen_top;
	logic              dir_top;
	logic [NODE_W-1:0] child0;
	logic [NODE_W-1:0] child1_top;
	logic              rank_ok;
	logic              is_u;
	logic              is_v;
	logic              leaf;
	logic              leaf_hit;
	logic              prune;

	assign push_idx   = sp_q[STK_AW-1:0];
	assign top_idx    = STK_AW'(sp_q - LVL_W'(1));
	assign node_top   = node_stk_q[top_idx];
	assign seen_top   = seen_stk_q[top_idx];
	assign dir_top    = dir_stk_q[top_idx];

	assign child0     = bwd_q ? (cur_q >> 1) : ((cur_q << 1) & node_mask);
	assign child1_top = bwd_q ? ((node_top >> 1) | node_high)
	                          : (((node_top << 1) | NODE_W'(1)) & node_mask);

	assign rank_ok  = (rd_data >= rank_limit);
	assign is_u     = (cur_q == start_node);
	assign is_v     = (cur_q == target_node);
	assign leaf     = (32'(sp_q) >= 32'(steps));
	assign leaf_hit = bwd_q ? (rank_ok && !is_u && !is_v && seen_q) : (rank_ok && seen_q);
	assign prune    = bwd_q ? ((sp_q != '0) && (!rank_ok || is_u)) : !rank_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			sp_q    <= '0;
			cur_q   <= '0;
			seen_q  <= 1'b0;
			bwd_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			cur_q   <= cur_d;
			seen_q  <= seen_d;
			bwd_q   <= bwd_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			node_stk_q[push_idx] <= cur_q;
			seen_stk_q[push_idx] <= seen_q | is_v;
			dir_stk_q[push_idx]  <= 1'b0;
		end else if (set_dir) begin
			dir_stk_q[top_idx] <= 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		sp_d    = sp_q;
		cur_d   = cur_q;
		seen_d  = seen_q;
		bwd_d   = bwd_q;
		cnt_d   = cnt_q;
		push    = 1'b0;
		set_dir = 1'b0;
		case (state_q)
			W_IDLE: begin
				if (ctl.start) begin
					cur_d   = start_node;
					sp_d    = '0;
					seen_d  = 1'b0;
					bwd_d   = 1'b0;
					cnt_d   = '0;
					state_d = (steps == '0) ? W_DONE : W_VISIT;
				end
			end
			W_VISIT: begin
				state_d = W_EVAL;
			end
			W_EVAL: begin
				if (leaf) begin
					if (leaf_hit) begin
						cnt_d = cnt_q + COST_W'(1);
					end
					state_d = W_POP;
				end else if (prune) begin
					state_d = W_POP;
				end else begin
					push    = 1'b1;
					sp_d    = sp_q + LVL_W'(1);
					cur_d   = child0;
					seen_d  = seen_q | is_v;
					state_d = W_VISIT;
				end
			end
			W_POP: begin
				if (sp_q == '0) begin
					if (!bwd_q) begin
						bwd_d   = 1'b1;
						cur_d   = start_node;
						seen_d  = 1'b0;
						state_d = W_VISIT;
					end else begin
						state_d = W_DONE;
					end
				end else if (!dir_top) begin
					set_dir = 1'b1;
					cur_d   = child1_top;
					seen_d  = seen_top;
					state_d = W_VISIT;
				end else begin
					sp_d = sp_q - LVL_W'(1);
				end
			end
			W_DONE: begin
				if (ctl.ack) begin
					state_d = W_IDLE;
				end
			end
			default: begin
				state_d = W_IDLE;
			end
		endcase
	end

	assign rd_en     = (state_q == W_VISIT);
	assign rd_addr   = cur_q;
	assign stat.done = (state_q == W_DONE);
	assign stat.cost = cnt_q;

endmodule

// ===== design/kmer_order_path_cost_unit.sv =====
// Top level of the k-mer order path cost unit: stream ports, registers, result register.
// Uses kopc_pkg, kopc_rank_mem and kopc_walker.
//
// Channel   Direction  Ports                               Carries
// s_*       in         s_tvalid s_tready s_tdata s_tuser   rank writes and cost queries
// m_*       out        m_tvalid m_tready m_tdata           one path cost per query
// cfg_*     in         cfg_we cfg_index cfg_data           path_length, kmer_bits
//
// A write item is accepted whenever the unit is idle. A query's run time grows with
// the nodes visited and the backtrack steps taken over both walks: each visit waits
// on the single registered rank read port and then takes one evaluation step. No new
// item is taken until the query's cost has moved to the output register.
// After reset path_length is 8 and kmer_bits is 10; the rank table is undefined until written.
// A finished cost waits in the output register while the next item is taken.
module kmer_order_path_cost_unit
	import kopc_pkg::*;
#(
	parameter int KMER_BITS_MAX  = 10,
	parameter int PATH_STEPS_MAX = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// entry_index, entry_rank, start_kmer, target_kmer, rank_limit, zero fill
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// op
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// path_cost, zero fill
	output logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NODE_W = KMER_BITS_MAX;

	logic [KMER_FLD_W-1:0] entry_index;
	logic [RANK_W-1:0]     entry_rank;
	logic [KMER_FLD_W-1:0] start_kmer;
	logic [KMER_FLD_W-1:0] target_kmer;
	logic [RANK_W-1:0]     rank_limit;

	assign entry_index = s_tdata[9:0];
	assign entry_rank  = s_tdata[20:10];
	assign start_kmer  = s_tdata[30:21];
	assign target_kmer = s_tdata[40:31];
	assign rank_limit  = s_tdata[51:41];

	top_state_t        state_q, state_d;
	logic [STEP_W-1:0] path_length_q;
	logic [KSEL_W-1:0] kmer_bits_q;
	logic [NODE_W-1:0] u_q;
	logic [NODE_W-1:0] v_q;
	logic [NODE_W-1:0] mask_q;
	logic [NODE_W-1:0] high_q;
	logic [RANK_W-1:0] limit_q;
	logic [STEP_W-1:0] steps_q;
	logic              m_tvalid_q;
	logic [COST_W-1:0] cost_q;

	logic              in_acc;
	logic              query_acc;
	logic              wr_en;
	logic [KCLAMP_W-1:0] k_sat;
	logic [STEP_W-1:0] w_sat;
	logic [NODE_W-1:0] mask_new;
	logic [NODE_W-1:0] high_new;
	walk_ctl_t         wctl;
	walk_stat_t        wstat;
	logic              rd_en;
	logic [NODE_W-1:0] rd_addr;
	logic [RANK_W-1:0] rd_data;

	assign s_tready  = (state_q == T_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign query_acc = in_acc && (s_tuser == OP_QUERY);
	assign wr_en     = in_acc && (s_tuser == OP_WRITE);

	always_comb begin
		if (kmer_bits_q < KSEL_W'(2)) begin
			k_sat = KCLAMP_W'(2);
		end else if (KCLAMP_W'(kmer_bits_q) > KCLAMP_W'(KMER_BITS_MAX)) begin
			k_sat = KCLAMP_W'(KMER_BITS_MAX);
		end else begin
			k_sat = KCLAMP_W'(kmer_bits_q);
		end
		if (path_length_q > STEP_W'(PATH_STEPS_MAX)) begin
			w_sat = STEP_W'(PATH_STEPS_MAX);
		end else begin
			w_sat = path_length_q;
		end
	end

	assign mask_new = ~({NODE_W{1'b1}} << k_sat);
	assign high_new = NODE_W'(1) << (k_sat - KCLAMP_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_length_q <= PATH_LENGTH_RST;
			kmer_bits_q   <= KMER_BITS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PATH_LENGTH: path_length_q <= cfg_data;
				CFG_KMER_BITS:   kmer_bits_q   <= cfg_data[KSEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			u_q     <= NODE_W'(start_kmer) & mask_new;
			v_q     <= NODE_W'(target_kmer) & mask_new;
			mask_q  <= mask_new;
			high_q  <= high_new;
			limit_q <= rank_limit;
			steps_q <= w_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		wctl.start = 1'b0;
		wctl.ack   = 1'b0;
		case (state_q)
			T_IDLE: begin
				if (query_acc) begin
					state_d = T_START;
				end
			end
			T_START: begin
				wctl.start = 1'b1;
				state_d    = T_RUN;
			end
			T_RUN: begin
				if (wstat.done && (!m_tvalid_q || m_tready)) begin
					wctl.ack = 1'b1;
					state_d  = T_IDLE;
				end
			end
			default: begin
				state_d = T_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (wctl.ack) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wctl.ack) begin
			cost_q <= wstat.cost;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(cost_q);

	kopc_rank_mem #(
		.ADDR_W (NODE_W),
		.DATA_W (RANK_W)
	) u_rank_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (NODE_W'(entry_index)),
		.wr_data (entry_rank),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	kopc_walker #(
		.NODE_W         (NODE_W),
		.PATH_STEPS_MAX (PATH_STEPS_MAX)
	) u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (wctl),
		.start_node  (u_q),
		.target_node (v_q),
		.node_mask   (mask_q),
		.node_high   (high_q),
		.rank_limit  (limit_q),
		.steps       (steps_q),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.stat        (wstat)
	);

	// The walker only finishes while the top level waits on it.
	assert property (@(posedge clk) disable iff (!arst_n)
		wstat.done |-> (state_q == T_RUN))
		else $error("walker finished outside of a running query");

	// A finished cost never overwrites a result that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		wctl.ack |-> (!m_tvalid_q || m_tready))
		else $error("result register overwritten");

	// Retiring a result returns the walker to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		wctl.ack |=> !wstat.done)
		else $error("walker stayed done after its result was taken");

endmodule
